/* hw/rtl/mel_pkg.sv */
// Shared types, character codes and classification helpers for the expression lexer.
`timescale 1ns / 1ps

package mel_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_DOT        = 8'h2E;
   localparam logic [7:0] CH_LPAREN     = 8'h28;
   localparam logic [7:0] CH_RPAREN     = 8'h29;
   localparam logic [7:0] CH_LCURLY     = 8'h7B;
   localparam logic [7:0] CH_RCURLY     = 8'h7D;
   localparam logic [7:0] CH_COMMA      = 8'h2C;
   localparam logic [7:0] CH_PLUS       = 8'h2B;
   localparam logic [7:0] CH_MINUS      = 8'h2D;
   localparam logic [7:0] CH_STAR       = 8'h2A;
   localparam logic [7:0] CH_SLASH      = 8'h2F;
   localparam logic [7:0] CH_CARET      = 8'h5E;
   localparam logic [7:0] CH_EQUAL      = 8'h3D;
   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_TAB        = 8'h09;
   localparam logic [7:0] CH_CR         = 8'h0D;

   typedef enum logic [3:0] {
      KIND_NUMBER   = 4'd0,
      KIND_SYMBOL   = 4'd1,
      KIND_FUNCTION = 4'd2,
      KIND_OPERATOR = 4'd3,
      KIND_LPAREN   = 4'd4,
      KIND_RPAREN   = 4'd5,
      KIND_LCURLY   = 4'd6,
      KIND_RCURLY   = 4'd7,
      KIND_COMMA    = 4'd8,
      KIND_UNKNOWN  = 4'd9
   } kind_type;

   typedef enum logic [2:0] {
      MODE_IDLE   = 3'b001,
      MODE_NUMBER = 3'b010,
      MODE_IDENT  = 3'b100
   } mode_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] start;
      logic [15:0] length;
      logic [7:0]  single_char;
      logic        last_of_run;
   } token_type;

   typedef struct packed {
      logic first;
      logic second;
   } push_type;

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= 8'h30) && (b <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
   endfunction

   function automatic logic ident_start(input logic [7:0] b);
      return is_alpha(b) || (b == CH_UNDERSCORE);
   endfunction

   function automatic logic ident_char(input logic [7:0] b);
      return is_alpha(b) || is_digit(b) || (b == CH_UNDERSCORE);
   endfunction

   function automatic kind_type one_byte_kind(input logic [7:0] b);
      kind_type k;
      unique case (b) inside
         CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET, CH_EQUAL: k = KIND_OPERATOR;
         CH_LPAREN: k = KIND_LPAREN;
         CH_RPAREN: k = KIND_RPAREN;
         CH_LCURLY: k = KIND_LCURLY;
         CH_RCURLY: k = KIND_RCURLY;
         CH_COMMA:  k = KIND_COMMA;
         default:   k = KIND_UNKNOWN;
      endcase
      return k;
   endfunction

endpackage

/* hw/rtl/mel_front.sv */
// Front end: classifies each byte, tracks the open token and builds up to two tokens.
`timescale 1ns / 1ps

module mel_front #(
   parameter int POSITION_WIDTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic [7:0]        text_byte,
   input  logic              end_of_text,
   output mel_pkg::push_type push,
   output mel_pkg::token_type tok0,
   output mel_pkg::token_type tok1
);
   import mel_pkg::*;

   localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;

   mode_type                  mode_ff, mode_in, mode_mid;
   logic                      dot_ff, dot_in, dot_mid;
   logic [POSITION_WIDTH-1:0] open_ff, open_in, open_mid;
   logic [POSITION_WIDTH-1:0] pos_ff, pos_in, pos_inc;

   logic     cont, close, fresh, opens_num, opens_id, single, flush;
   kind_type close_kind;
   token_type tok_a, tok_b;

   // Saturating length: end minus start, at least one, clamped to 16 bits.
   function automatic logic [15:0] tok_len(input logic [POSITION_WIDTH-1:0] s,
                                           input logic [POSITION_WIDTH-1:0] e);
      logic [31:0] wide;
      wide = 32'(e - s);
      if (e <= s) return 16'd1;
      return (wide > 32'h0000_FFFF) ? 16'hFFFF : wide[15:0];
   endfunction

   function automatic logic [15:0] tok_pos(input logic [POSITION_WIDTH-1:0] s);
      logic [31:0] wide;
      wide = 32'(s);
      return wide[15:0];
   endfunction

   always_comb begin
      pos_inc = (pos_ff == POS_MAX) ? pos_ff : pos_ff + POSITION_WIDTH'(1);

      unique case (mode_ff)
         MODE_NUMBER: cont = is_digit(text_byte) || (text_byte == CH_UNDERSCORE) ||
                             ((text_byte == CH_DOT) && !dot_ff);
         MODE_IDENT:  cont = ident_char(text_byte);
         MODE_IDLE:   cont = 1'b0;
         default:     cont = 1'b0;
      endcase

      close = (mode_ff != MODE_IDLE) && !cont;
      fresh = !cont;
      if (mode_ff == MODE_NUMBER)      close_kind = KIND_NUMBER;
      else if (text_byte == CH_LPAREN) close_kind = KIND_FUNCTION;
      else                             close_kind = KIND_SYMBOL;

      opens_num = fresh && is_digit(text_byte);
      opens_id  = fresh && ident_start(text_byte);
      single    = fresh && !is_space(text_byte) && !is_digit(text_byte) &&
                  !ident_start(text_byte);

      mode_mid = cont ? mode_ff : MODE_IDLE;
      dot_mid  = dot_ff;
      open_mid = open_ff;
      if (cont && (text_byte == CH_DOT)) dot_mid = 1'b1;
      if (opens_num) begin
         mode_mid = MODE_NUMBER;
         dot_mid  = 1'b0;
         open_mid = pos_ff;
      end else if (opens_id) begin
         mode_mid = MODE_IDENT;
         open_mid = pos_ff;
      end

      flush = end_of_text && (mode_mid != MODE_IDLE);

      // Closing token for the run that this byte ended.
      tok_a.kind        = close_kind;
      tok_a.start       = tok_pos(open_ff);
      tok_a.length      = tok_len(open_ff, pos_ff);
      tok_a.single_char = 8'd0;
      tok_a.last_of_run = 1'b0;

      // One-byte token, or the run flushed at end of text.
      if (single) begin
         tok_b.kind        = one_byte_kind(text_byte);
         tok_b.start       = tok_pos(pos_ff);
         tok_b.length      = 16'd1;
         tok_b.single_char = text_byte;
      end else begin
         tok_b.kind        = (mode_mid == MODE_NUMBER) ? KIND_NUMBER : KIND_SYMBOL;
         tok_b.start       = tok_pos(open_mid);
         tok_b.length      = tok_len(open_mid, pos_inc);
         tok_b.single_char = 8'd0;
      end
      tok_b.last_of_run = 1'b1;

      push.first  = take && (close || single || flush);
      push.second = take && close && (single || flush);
      if (close) begin
         tok0             = tok_a;
         tok0.last_of_run = !(single || flush);
         tok1             = tok_b;
      end else begin
         tok0 = tok_b;
         tok1 = tok_b;
      end

      mode_in = mode_ff;
      dot_in  = dot_ff;
      open_in = open_ff;
      pos_in  = pos_ff;
      if (take) begin
         if (end_of_text) begin
            mode_in = MODE_IDLE;
            dot_in  = 1'b0;
            open_in = '0;
            pos_in  = '0;
         end else begin
            mode_in = mode_mid;
            dot_in  = dot_mid;
            open_in = open_mid;
            pos_in  = pos_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         dot_ff  <= 1'b0;
         open_ff <= '0;
         pos_ff  <= '0;
      end else begin
         mode_ff <= mode_in;
         dot_ff  <= dot_in;
         open_ff <= open_in;
         pos_ff  <= pos_in;
      end
   end

endmodule

/* hw/rtl/mel_queue.sv */
// Token queue between front and back: up to two writes and one read per cycle.
`timescale 1ns / 1ps

module mel_queue (
   input  logic               clock,
   input  logic               reset,
   input  mel_pkg::push_type  push,
   input  mel_pkg::token_type tok0,
   input  mel_pkg::token_type tok1,
   input  logic               pop,
   output logic               full,
   output logic               not_empty,
   output mel_pkg::token_type head
);
   import mel_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   token_type         entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     n_push;

   always_comb begin
      n_push    = CW'(push.first) + CW'(push.second);
      wr_in     = wr_ff + PW'(n_push);
      rd_in     = rd_ff + PW'(pop);
      count_in  = count_ff + n_push - CW'(pop);
      not_empty = (count_ff != '0);
      // Hold off the front until two slots are free.
      full      = (count_ff > CW'(QUEUE_DEPTH - 2));
      head      = entry_ff[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (push.first)  entry_ff[wr_ff] <= tok0;
      if (push.second) entry_ff[wr_ff + PW'(1)] <= tok1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

/* hw/rtl/mel_back.sv */
// Back end: drains the token queue into the registered result channel.
`timescale 1ns / 1ps

module mel_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               not_empty,
   input  mel_pkg::token_type head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output mel_pkg::token_type rsp_tok
);
   import mel_pkg::*;

   logic      valid_ff, valid_in;
   token_type tok_ff, tok_in;

   always_comb begin
      pop      = not_empty && (!valid_ff || !rsp_stall);
      valid_in = pop || (valid_ff && rsp_stall);
      tok_in   = pop ? head : tok_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_tok   = tok_ff;

endmodule

/* hw/rtl/math_expression_lexer.sv */
// Top level of the math expression lexer: one text byte in, tokens out.
// Each byte's tokens pass through the token queue and then the result register to rsp_.
// Throughput: one byte per cycle while each byte yields at most one token and rsp_stall
//   stays low; the result register drains one token per cycle, so two-token bytes fill the queue.
// Reset: synchronous, active high; clears scan state, positions, queue and rsp_valid.
`timescale 1ns / 1ps

module math_expression_lexer #(
   parameter int POSITION_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_text_byte,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_token_kind,
   output logic [15:0] rsp_token_start,
   output logic [15:0] rsp_token_length,
   output logic [7:0]  rsp_single_char,
   output logic        rsp_last_of_run
);
   import mel_pkg::*;

   logic      take, q_full, q_not_empty, pop;
   push_type  push;
   token_type tok0, tok1, head, rsp_tok;

   // Transfer a byte whenever the queue has room for the two tokens it may produce.
   assign req_stall = q_full;
   assign take      = req_valid && !req_stall;

   // Front: classify the byte, advance the open-token state, build tokens.
   mel_front #(
      .POSITION_WIDTH (POSITION_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .text_byte   (req_text_byte),
      .end_of_text (req_end_of_text),
      .push        (push),
      .tok0        (tok0),
      .tok1        (tok1)
   );

   // Queue decouples the front from result-side stalls.
   mel_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .tok0      (tok0),
      .tok1      (tok1),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (head)
   );

   // Back: hold each token in the result register until it transfers.
   mel_back u_back (
      .clock     (clock),
      .reset     (reset),
      .not_empty (q_not_empty),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_tok   (rsp_tok)
   );

   assign rsp_token_kind   = rsp_tok.kind;
   assign rsp_token_start  = rsp_tok.start;
   assign rsp_token_length = rsp_tok.length;
   assign rsp_single_char  = rsp_tok.single_char;
   assign rsp_last_of_run  = rsp_tok.last_of_run;

endmodule

/* hw/rtl/mel_checker.sv */
// Port-level checks for the math expression lexer, bound to the top level.
`timescale 1ns / 1ps

module mel_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [3:0]  rsp_token_kind,
   input logic [15:0] rsp_token_start,
   input logic [15:0] rsp_token_length,
   input logic [7:0]  rsp_single_char
);
   import mel_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_token_start))
      else $error("result dropped or changed while stalled");

   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_token_length != 16'd0)
      else $error("zero token length");

   a_run_no_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_token_kind == KIND_NUMBER || rsp_token_kind == KIND_SYMBOL ||
                    rsp_token_kind == KIND_FUNCTION)
      |-> rsp_single_char == 8'd0)
      else $error("run token carries a character");

   a_single_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !(rsp_token_kind == KIND_NUMBER || rsp_token_kind == KIND_SYMBOL ||
                     rsp_token_kind == KIND_FUNCTION)
      |-> rsp_token_length == 16'd1)
      else $error("one-byte token with length other than one");

endmodule

bind math_expression_lexer mel_checker u_mel_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_token_kind   (rsp_token_kind),
   .rsp_token_start  (rsp_token_start),
   .rsp_token_length (rsp_token_length),
   .rsp_single_char  (rsp_single_char)
);

/* bench/lexer_token_checker.sv */
// Token checker for the expression lexer: predicts tokens from accepted bytes and compares.
`timescale 1ns / 1ps

module lexer_token_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_text_byte,
   input  logic        req_end_of_text,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [3:0]  rsp_token_kind,
   input  logic [15:0] rsp_token_start,
   input  logic [15:0] rsp_token_length,
   input  logic [7:0]  rsp_single_char,
   input  logic        rsp_last_of_run,
   output int          mismatches,
   output int          outstanding,
   output int          tokens_checked
);
   import mel_pkg::*;

   localparam logic [15:0] POS_LIMIT = 16'hFFFF;

   token_type   tokens_due [$];
   mode_type    scan_state;
   logic        number_has_dot;
   logic [15:0] token_origin;
   logic [15:0] cursor;

   function automatic logic digit_char(input logic [7:0] b);
      return b inside {[8'h30 : 8'h39]};
   endfunction

   function automatic logic letter_char(input logic [7:0] b);
      return b inside {[8'h41 : 8'h5A], [8'h61 : 8'h7A]};
   endfunction

   function automatic logic blank_char(input logic [7:0] b);
      return b inside {CH_SPACE, [CH_TAB : CH_CR]};
   endfunction

   function automatic kind_type single_kind(input logic [7:0] b);
      if (b inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET, CH_EQUAL})
         return KIND_OPERATOR;
      if (b == CH_LPAREN) return KIND_LPAREN;
      if (b == CH_RPAREN) return KIND_RPAREN;
      if (b == CH_LCURLY) return KIND_LCURLY;
      if (b == CH_RCURLY) return KIND_RCURLY;
      if (b == CH_COMMA)  return KIND_COMMA;
      return KIND_UNKNOWN;
   endfunction

   function automatic logic [15:0] next_pos(input logic [15:0] p);
      return (p == POS_LIMIT) ? p : p + 16'd1;
   endfunction

   task automatic push_token(input kind_type kind, input logic [15:0] first,
                             input logic [15:0] stop, input logic [7:0] ch);
      token_type t;
      t.kind        = kind;
      t.start       = first;
      t.length      = (stop > first) ? stop - first : 16'd1;
      t.single_char = ch;
      t.last_of_run = 1'b0;
      tokens_due.insert(tokens_due.size(), t);
   endtask

   // Advance the scan state by one byte and queue the tokens it closes.
   task automatic lex_byte(input logic [7:0] b, input logic last);
      logic [15:0] p;
      logic        fresh;
      int          depth_in;
      p        = cursor;
      fresh    = 1'b1;
      depth_in = tokens_due.size();
      case (scan_state)
         MODE_NUMBER: begin
            if (digit_char(b) || b == CH_UNDERSCORE || (b == CH_DOT && !number_has_dot)) begin
               if (b == CH_DOT) number_has_dot = 1'b1;
               fresh = 1'b0;
            end else begin
               push_token(KIND_NUMBER, token_origin, p, 8'h00);
               scan_state = MODE_IDLE;
            end
         end
         MODE_IDENT: begin
            if (letter_char(b) || digit_char(b) || b == CH_UNDERSCORE) begin
               fresh = 1'b0;
            end else begin
               push_token((b == CH_LPAREN) ? KIND_FUNCTION : KIND_SYMBOL,
                          token_origin, p, 8'h00);
               scan_state = MODE_IDLE;
            end
         end
         default: scan_state = MODE_IDLE;
      endcase

      if (fresh && !blank_char(b)) begin
         if (digit_char(b)) begin
            scan_state     = MODE_NUMBER;
            number_has_dot = 1'b0;
            token_origin   = p;
         end else if (letter_char(b) || b == CH_UNDERSCORE) begin
            scan_state   = MODE_IDENT;
            token_origin = p;
         end else begin
            push_token(single_kind(b), p, next_pos(p), b);
         end
      end

      // Flush the open token on the last byte of a text, then start over.
      if (last) begin
         if (scan_state == MODE_NUMBER)
            push_token(KIND_NUMBER, token_origin, next_pos(p), 8'h00);
         else if (scan_state == MODE_IDENT)
            push_token(KIND_SYMBOL, token_origin, next_pos(p), 8'h00);
         scan_state     = MODE_IDLE;
         number_has_dot = 1'b0;
         token_origin   = '0;
         cursor         = '0;
      end else begin
         cursor = next_pos(p);
      end

      if (tokens_due.size() > depth_in)
         tokens_due[tokens_due.size() - 1].last_of_run = 1'b1;
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("[%0t] token %0d: %s got %0h expected %0h", $realtime, tokens_checked,
               what, got, want);
      mismatches++;
   endtask

   task automatic check_token();
      token_type want;
      if (tokens_due.size() == 0) begin
         report_mismatch("unexpected token, kind", 32'(rsp_token_kind), 32'd0);
      end else begin
         want = tokens_due.pop_front();
         if (rsp_token_kind !== want.kind)
            report_mismatch("kind", 32'(rsp_token_kind), 32'(want.kind));
         if (rsp_token_start !== want.start)
            report_mismatch("start", 32'(rsp_token_start), 32'(want.start));
         if (rsp_token_length !== want.length)
            report_mismatch("length", 32'(rsp_token_length), 32'(want.length));
         if (rsp_single_char !== want.single_char)
            report_mismatch("single_char", 32'(rsp_single_char), 32'(want.single_char));
         if (rsp_last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", 32'(rsp_last_of_run), 32'(want.last_of_run));
      end
      tokens_checked++;
   endtask

   initial begin
      mismatches     = 0;
      outstanding    = 0;
      tokens_checked = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         scan_state     = MODE_IDLE;
         number_has_dot = 1'b0;
         token_origin   = '0;
         cursor         = '0;
         tokens_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) check_token();
         if (req_valid && !req_stall) lex_byte(req_text_byte, req_end_of_text);
      end
      outstanding = tokens_due.size();
   end

endmodule

/* bench/tb_math_expression_lexer.sv */
// Testbench top for the expression lexer: byte stimulus, result-side stalls and verdict.
`timescale 1ns / 1ps

module tb_math_expression_lexer;
   import mel_pkg::*;

   localparam int  RANDOM_BYTES  = 600;
   localparam int  DRAIN_CYCLES  = 16;
   localparam time RUN_LIMIT_NS = 2_000_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_text_byte = 8'h00;
   logic        req_end_of_text = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_token_kind;
   logic [15:0] rsp_token_start;
   logic [15:0] rsp_token_length;
   logic [7:0]  rsp_single_char;
   logic        rsp_last_of_run;

   int mismatches;
   int outstanding;
   int tokens_checked;

   // Sender pacing and run statistics.
   bit gaps_on = 1'b1;
   int burst_left = 4;
   int bytes_sent = 0;
   int texts_sent = 0;

   // Bytes of the random text being built.
   logic [7:0] text_q [$];

   logic [7:0] op_chars    [6] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET, CH_EQUAL};
   logic [7:0] punct_chars [5] = '{CH_LPAREN, CH_RPAREN, CH_LCURLY, CH_RCURLY, CH_COMMA};
   logic [7:0] blank_chars [6] = '{CH_SPACE, CH_TAB, 8'h0A, 8'h0B, 8'h0C, CH_CR};

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   math_expression_lexer u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_text_byte    (req_text_byte),
      .req_end_of_text  (req_end_of_text),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_start  (rsp_token_start),
      .rsp_token_length (rsp_token_length),
      .rsp_single_char  (rsp_single_char),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   lexer_token_checker u_token_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_text_byte    (req_text_byte),
      .req_end_of_text  (req_end_of_text),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_start  (rsp_token_start),
      .rsp_token_length (rsp_token_length),
      .rsp_single_char  (rsp_single_char),
      .rsp_last_of_run  (rsp_last_of_run),
      .mismatches       (mismatches),
      .outstanding      (outstanding),
      .tokens_checked   (tokens_checked)
   );

   // Append one byte to the text being built.
   task automatic append_char(input logic [7:0] b);
      text_q.insert(text_q.size(), b);
   endtask

   // Offer one byte and hold it until the lexer takes the transfer. Afterwards,
   // when the current burst is used up, drop valid for a random gap (with junk
   // on the data lines) and pick the next burst length.
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      req_valid       <= 1'b1;
      req_text_byte   <= b;
      req_end_of_text <= last;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      if (last) texts_sent++;
      if (gaps_on) begin
         if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            req_valid       <= 1'b0;
            req_text_byte   <= 8'($urandom);
            req_end_of_text <= 1'($urandom);
            repeat (gap) @(posedge clock);
            burst_left = $urandom_range(0, 12);
         end else begin
            burst_left--;
         end
      end
   endtask

   // Send a whole text; its final byte carries the end-of-text flag.
   task automatic send_string(input string s);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], i == s.len() - 1);
   endtask

   // Result side: stall on changing patterns. Every seventh segment is a long
   // hold-off so the lexer's output queue fills and it has to stall its input.
   initial begin
      int segment;
      int span;
      int style;
      segment = 0;
      wait (!reset);
      forever begin
         if (segment % 7 == 2) begin
            span = $urandom_range(40, 80);
            repeat (span) begin
               @(posedge clock);
               rsp_stall <= 1'b1;
            end
         end else begin
            span  = $urandom_range(10, 60);
            style = $urandom_range(0, 3);
            for (int i = 0; i < span; i++) begin
               @(posedge clock);
               case (style)
                  0:       rsp_stall <= 1'b0;
                  1:       rsp_stall <= ($urandom_range(0, 3) == 0);
                  2:       rsp_stall <= ($urandom_range(0, 3) != 0);
                  default: rsp_stall <= i[0];
               endcase
            end
         end
         segment++;
      end
   end

   initial begin
      int random_bytes;
      int n_tokens;
      int pick;
      int len;

      random_bytes = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed texts:
      //  - identifier before '(' becomes a function, second dot closes a number
      //  - underscore identifier, comma, curly braces, bytes above 127
      //  - every whitespace byte and every operator
      //  - a one-byte text whose only byte both opens and flushes a token
      //  - identifier flushed at the end is a symbol, a NUL byte is unknown
      send_string("f(1.2.)");
      send_string("{_x,9}\200\377");
      send_string("\011\012\013\014\015 +-*/^=");
      send_string("7");
      send_string("ab");
      send_string("g(");
      send_byte(8'h00, 1'b1);

      // Random texts: mostly well-formed expressions with random content, with
      // a sprinkling of arbitrary bytes. Adjacent tokens without spacing are
      // common, so numbers get closed by letters and the like.
      while (random_bytes < RANDOM_BYTES) begin
         gaps_on  = ($urandom_range(0, 3) != 0);
         n_tokens = $urandom_range(1, 10);
         text_q.delete();
         repeat (n_tokens) begin
            pick = $urandom_range(0, 99);
            if (pick < 22) begin
               len = $urandom_range(0, 5);
               append_char(8'(8'h30 + $urandom_range(0, 9)));
               repeat (len) begin
                  case ($urandom_range(0, 9))
                     0:       append_char(CH_UNDERSCORE);
                     1:       append_char(CH_DOT);
                     default: append_char(8'(8'h30 + $urandom_range(0, 9)));
                  endcase
               end
            end else if (pick < 52) begin
               len = $urandom_range(0, 5);
               case ($urandom_range(0, 5)) inside
                  0:       append_char(CH_UNDERSCORE);
                  1, 2:    append_char(8'(8'h41 + $urandom_range(0, 25)));
                  default: append_char(8'(8'h61 + $urandom_range(0, 25)));
               endcase
               repeat (len) begin
                  case ($urandom_range(0, 3))
                     0:       append_char(CH_UNDERSCORE);
                     1:       append_char(8'(8'h30 + $urandom_range(0, 9)));
                     2:       append_char(8'(8'h41 + $urandom_range(0, 25)));
                     default: append_char(8'(8'h61 + $urandom_range(0, 25)));
                  endcase
               end
               // Turn some identifiers into function calls.
               if (pick >= 42) append_char(CH_LPAREN);
            end else if (pick < 70) begin
               append_char(op_chars[$urandom_range(0, 5)]);
            end else if (pick < 82) begin
               append_char(punct_chars[$urandom_range(0, 4)]);
            end else if (pick < 94) begin
               repeat ($urandom_range(1, 3)) append_char(blank_chars[$urandom_range(0, 5)]);
            end else begin
               append_char(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 2) == 0) append_char(CH_SPACE);
         end
         foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
         random_bytes += text_q.size();
      end

      // Drain: hold valid low, let every expected token arrive, then watch a
      // little longer for stray tokens.
      req_valid <= 1'b0;
      @(posedge clock);
      wait (outstanding == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d bytes in %0d texts and compared %0d tokens,", bytes_sent,
               texts_sent, tokens_checked);
      $display("including every byte class, bursty input and long result-side stalls.");
      if (mismatches == 0 && outstanding == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Watchdog: stop a hung run.
   initial begin
      #(RUN_LIMIT_NS);
      $display("Run exceeded its time limit with %0d tokens outstanding", outstanding);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
